>>> hw/rtl/fjms_pkg.sv
// Shared types and constants for the flat JSON member scanner.
package fjms_pkg;

   localparam int MAX_BUFFER  = 4096;
   localparam int NEST_LIMIT  = 255;
   localparam int MANT_BITS   = 48;
   localparam int MAG_W       = MANT_BITS - 1;
   localparam int OFF_W       = $clog2(MAX_BUFFER);
   localparam int POS_W       = OFF_W + 1;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 120;

   // Parser phase, one-hot.
   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_NAME       = 8'b0000_0010,
      PH_AFTERNAME  = 8'b0000_0100,
      PH_PREVALUE   = 8'b0000_1000,
      PH_VALUE      = 8'b0001_0000,
      PH_AFTERVALUE = 8'b0010_0000,
      PH_AGAIN      = 8'b0100_0000,
      PH_DONE       = 8'b1000_0000
   } phase_type;

   localparam logic [1:0] VT_OBJECT = 2'd0;
   localparam logic [1:0] VT_ARRAY  = 2'd1;
   localparam logic [1:0] VT_STRING = 2'd2;
   localparam logic [1:0] VT_NUMBER = 2'd3;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NAME      = 3'd1;
   localparam logic [2:0] ERR_SYNTAX    = 3'd2;
   localparam logic [2:0] ERR_ENTRIES   = 3'd3;
   localparam logic [2:0] ERR_NUL       = 3'd4;
   localparam logic [2:0] ERR_TOO_LONG  = 3'd5;

   localparam logic RK_ENTRY   = 1'b0;
   localparam logic RK_SUMMARY = 1'b1;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_POINT  = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   // Response data word; first member is the most significant.
   typedef struct packed {
      logic [4:0]           pad;
      logic [2:0]           error_code;
      logic                 number_overflow;
      logic [4:0]           fraction_digits;
      logic [MANT_BITS-1:0] number_mantissa;
      logic [OFF_W-1:0]     value_len;
      logic [OFF_W-1:0]     value_start;
      logic [1:0]           value_type;
      logic [OFF_W-1:0]     name_len;
      logic [OFF_W-1:0]     name_start;
      logic [7:0]           entry_number;
   } rsp_data_type;

   typedef struct packed {
      logic         result_kind;
      rsp_data_type data;
      logic         last_of_run;
   } result_type;

endpackage

>>> hw/rtl/flat_json_member_scanner_top.sv
// Flat JSON member scanner: one-byte-per-cycle parser with a small result queue.
// A result is written into the result queue at the clock edge that accepts the request that causes it.
// Throughput: one request per cycle; a request yields at most two results (member, summary).
// The request side stalls only while the four-entry result queue lacks room for two results.
// Reset clears the parser state and queue and loads max_entries with 16; no clearing pass.
module flat_json_member_scanner_top
   import fjms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] char_byte
   input  logic                  req_tlast,   // buffer_end
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] entry_number, [19:8] name_start, [31:20] name_len, [33:32] value_type,
   // [45:34] value_start, [57:46] value_len, [105:58] number_mantissa,
   // [110:106] fraction_digits, [111] number_overflow, [114:112] error_code,
   // [119:115] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,   // result_kind
   output logic                  rsp_tlast,   // last_of_run
   // configuration
   input  logic                  csr_wr_en,
   input  logic [7:0]            csr_wr_data  // max_entries
);

   // ---------------------------------------------------------------------------------------
   // Parser state
   // ---------------------------------------------------------------------------------------
   phase_type        phase_ff,    phase_in;
   logic [1:0]       kind_ff,     kind_in;
   logic [7:0]       index_ff,    index_in;
   logic [POS_W-1:0] pos_ff,      pos_in;
   logic [OFF_W-1:0] name_off_ff, name_off_in;
   logic [OFF_W-1:0] name_len_ff, name_len_in;
   logic [OFF_W-1:0] val_off_ff,  val_off_in;
   logic [OFF_W-1:0] val_len_ff,  val_len_in;
   logic [7:0]       depth_ff,    depth_in;
   logic             esc_ff,      esc_in;
   logic             neg_ff,      neg_in;
   logic [MAG_W-1:0] mant_ff,     mant_in;
   logic [4:0]       frac_ff,     frac_in;
   logic             point_ff,    point_in;
   logic             sat_ff,      sat_in;
   logic [2:0]       err_ff,      err_in;
   logic [7:0]       limit_ff;

   // result queue
   result_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff,  count_in;

   logic       req_acc;
   logic       rsp_acc;
   logic       emit;
   result_type entry_res;
   result_type summary_res;
   result_type slot0;
   logic [1:0] push_cnt;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Accept only while two free slots are guaranteed.
   assign req_tready = (count_ff < (FIFO_AW+1)'(FIFO_DEPTH - 1));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].data;
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].result_kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_of_run;

   // ---------------------------------------------------------------------------------------
   // One-byte scan step
   // ---------------------------------------------------------------------------------------
   always_comb begin
      logic [7:0]       c;
      logic             is_sp;
      logic             is_digit;
      logic [OFF_W-1:0] pos_lo;
      logic [3:0]       digit;
      logic [MAG_W+3:0] mac;
      logic [7:0]       open_ch;
      logic [7:0]       close_ch;
      logic [8:0]       idx_next;

      c        = req_tdata[7:0];
      is_sp    = (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF});
      is_digit = (c inside {[CH_ZERO:CH_NINE]});
      pos_lo   = pos_ff[OFF_W-1:0];
      digit    = 4'(c - CH_ZERO);
      mac      = ({4'b0, mant_ff} << 3) + ({4'b0, mant_ff} << 1) + (MAG_W+4)'(digit);
      open_ch  = (kind_ff == VT_OBJECT) ? CH_LBRACE : CH_LBRACK;
      close_ch = (kind_ff == VT_OBJECT) ? CH_RBRACE : CH_RBRACK;
      idx_next = {1'b0, index_ff} + 9'd1;

      phase_in    = phase_ff;
      kind_in     = kind_ff;
      index_in    = index_ff;
      name_off_in = name_off_ff;
      name_len_in = name_len_ff;
      val_off_in  = val_off_ff;
      val_len_in  = val_len_ff;
      depth_in    = depth_ff;
      esc_in      = esc_ff;
      neg_in      = neg_ff;
      mant_in     = mant_ff;
      frac_in     = frac_ff;
      point_in    = point_ff;
      sat_in      = sat_ff;
      err_in      = err_ff;
      emit        = 1'b0;

      // Offset saturates at the buffer size.
      pos_in = (pos_ff < POS_W'(MAX_BUFFER)) ? pos_ff + POS_W'(1) : pos_ff;

      if (phase_ff != PH_DONE) begin
         if (pos_ff >= POS_W'(MAX_BUFFER)) begin
            err_in   = ERR_TOO_LONG;
            phase_in = PH_DONE;
         end else if (c == CH_NUL) begin
            err_in   = ERR_NUL;
            phase_in = PH_DONE;
         end else if (limit_ff == 8'd0) begin
            err_in   = ERR_ENTRIES;
            phase_in = PH_DONE;
         end else begin
            case (phase_ff)
               PH_IDLE, PH_AGAIN: begin
                  // Skip blanks, and any brace before the first name.
                  if (is_sp || (phase_ff == PH_IDLE && c == CH_LBRACE)) begin
                     phase_in = phase_ff;
                  end else if (c == CH_QUOTE) begin
                     phase_in    = PH_NAME;
                     name_off_in = pos_lo + OFF_W'(1);
                     name_len_in = '0;
                  end else begin
                     err_in   = ERR_NAME;
                     phase_in = PH_DONE;
                  end
               end
               PH_NAME: begin
                  if (c == CH_QUOTE) begin
                     phase_in = PH_AFTERNAME;
                  end else begin
                     name_len_in = name_len_ff + OFF_W'(1);
                  end
               end
               PH_AFTERNAME: begin
                  if (c == CH_COLON) begin
                     phase_in = PH_PREVALUE;
                  end else if (!is_sp) begin
                     err_in   = ERR_SYNTAX;
                     phase_in = PH_DONE;
                  end
               end
               PH_PREVALUE: begin
                  if (!is_sp) begin
                     // Open a value: clear the per-value state.
                     val_len_in = '0;
                     val_off_in = pos_lo + OFF_W'(1);
                     depth_in   = '0;
                     esc_in     = 1'b0;
                     neg_in     = 1'b0;
                     mant_in    = '0;
                     frac_in    = '0;
                     point_in   = 1'b0;
                     sat_in     = 1'b0;
                     phase_in   = PH_VALUE;
                     if (c == CH_QUOTE) begin
                        kind_in = VT_STRING;
                     end else if (c == CH_LBRACE) begin
                        kind_in = VT_OBJECT;
                     end else if (c == CH_LBRACK) begin
                        kind_in = VT_ARRAY;
                     end else if (c == CH_MINUS || is_digit) begin
                        kind_in    = VT_NUMBER;
                        val_off_in = pos_lo;
                        val_len_in = OFF_W'(1);
                        neg_in     = (c == CH_MINUS);
                        mant_in    = (c == CH_MINUS) ? '0 : MAG_W'(digit);
                     end else begin
                        err_in   = ERR_SYNTAX;
                        phase_in = PH_DONE;
                     end
                  end
               end
               PH_VALUE: begin
                  case (kind_ff)
                     VT_STRING: begin
                        if (esc_ff) begin
                           esc_in     = 1'b0;
                           val_len_in = val_len_ff + OFF_W'(1);
                        end else if (c == CH_QUOTE) begin
                           emit     = 1'b1;
                           phase_in = PH_AFTERVALUE;
                        end else begin
                           esc_in     = (c == CH_BSLASH);
                           val_len_in = val_len_ff + OFF_W'(1);
                        end
                     end
                     VT_OBJECT, VT_ARRAY: begin
                        // Count only brackets of the value's own kind.
                        if (c == close_ch) begin
                           if (depth_ff != 8'd0) begin
                              depth_in   = depth_ff - 8'd1;
                              val_len_in = val_len_ff + OFF_W'(1);
                           end else begin
                              emit     = 1'b1;
                              phase_in = PH_AFTERVALUE;
                           end
                        end else begin
                           if (c == open_ch && depth_ff != 8'(NEST_LIMIT)) begin
                              depth_in = depth_ff + 8'd1;
                           end
                           val_len_in = val_len_ff + OFF_W'(1);
                        end
                     end
                     default: begin
                        if (is_digit) begin
                           // Times ten plus digit; saturate past the magnitude limit.
                           if (mac[MAG_W+3:MAG_W] != 4'd0) begin
                              mant_in = '1;
                              sat_in  = 1'b1;
                           end else begin
                              mant_in = mac[MAG_W-1:0];
                           end
                           if (point_ff) begin
                              if (frac_ff == 5'd31) begin
                                 sat_in = 1'b1;
                              end else begin
                                 frac_in = frac_ff + 5'd1;
                              end
                           end
                           val_len_in = val_len_ff + OFF_W'(1);
                        end else if (c == CH_POINT) begin
                           if (point_ff) begin
                              err_in   = ERR_SYNTAX;
                              phase_in = PH_DONE;
                           end else begin
                              point_in   = 1'b1;
                              val_len_in = val_len_ff + OFF_W'(1);
                           end
                        end else if (is_sp) begin
                           emit     = 1'b1;
                           phase_in = PH_AFTERVALUE;
                        end else if (c == CH_RBRACE) begin
                           emit     = 1'b1;
                           phase_in = PH_DONE;
                        end else if (c == CH_COMMA) begin
                           emit = 1'b1;
                           if (idx_next >= {1'b0, limit_ff}) begin
                              err_in   = ERR_ENTRIES;
                              phase_in = PH_DONE;
                           end else begin
                              phase_in = PH_AGAIN;
                           end
                        end else begin
                           err_in   = ERR_SYNTAX;
                           phase_in = PH_DONE;
                        end
                     end
                  endcase
               end
               PH_AFTERVALUE: begin
                  if (c == CH_RBRACE) begin
                     phase_in = PH_DONE;
                  end else if (c == CH_COMMA) begin
                     if (index_ff >= limit_ff) begin
                        err_in   = ERR_ENTRIES;
                        phase_in = PH_DONE;
                     end else begin
                        phase_in = PH_AGAIN;
                     end
                  end else if (!is_sp) begin
                     err_in   = ERR_SYNTAX;
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end

      if (emit) begin
         index_in = index_ff + 8'd1;
      end

      // Member entry, built from the state before this byte.
      entry_res                        = '0;
      entry_res.result_kind            = RK_ENTRY;
      entry_res.data.entry_number      = index_ff;
      entry_res.data.name_start        = name_off_ff;
      entry_res.data.name_len          = name_len_ff;
      entry_res.data.value_type        = kind_ff;
      entry_res.data.value_start       = val_off_ff;
      entry_res.data.value_len         = val_len_ff;
      entry_res.data.error_code        = ERR_NONE;
      entry_res.last_of_run            = !req_tlast;
      if (kind_ff == VT_NUMBER) begin
         entry_res.data.number_mantissa = neg_ff ? -{1'b0, mant_ff} : {1'b0, mant_ff};
         entry_res.data.fraction_digits = frac_ff;
         entry_res.data.number_overflow = sat_ff;
      end

      // End-of-buffer summary, built from the state after this byte.
      summary_res                   = '0;
      summary_res.result_kind       = RK_SUMMARY;
      summary_res.data.entry_number = index_in;
      summary_res.data.error_code   = err_in;
      summary_res.last_of_run       = 1'b1;

      slot0    = emit ? entry_res : summary_res;
      push_cnt = {1'b0, emit} + {1'b0, req_tlast};
   end

   // ---------------------------------------------------------------------------------------
   // Queue pointers
   // ---------------------------------------------------------------------------------------
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_acc) begin
         wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_cnt);
         count_in  = count_ff + (FIFO_AW+1)'(push_cnt);
      end
      if (rsp_acc) begin
         rd_ptr_in = rd_ptr_ff + FIFO_AW'(1);
         count_in  = count_in - (FIFO_AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue payload: write the first result at the write pointer, the summary behind it.
   always_ff @(posedge clock) begin
      if (req_acc && push_cnt != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= slot0;
         if (push_cnt == 2'd2) begin
            fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= summary_res;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Configuration register
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 8'd16;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Parser state update; the last byte of a buffer restarts the parser.
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset || (req_acc && req_tlast)) begin
         phase_ff    <= PH_IDLE;
         kind_ff     <= '0;
         index_ff    <= '0;
         pos_ff      <= '0;
         name_off_ff <= '0;
         name_len_ff <= '0;
         val_off_ff  <= '0;
         val_len_ff  <= '0;
         depth_ff    <= '0;
         esc_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         mant_ff     <= '0;
         frac_ff     <= '0;
         point_ff    <= 1'b0;
         sat_ff      <= 1'b0;
         err_ff      <= ERR_NONE;
      end else if (req_acc) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         index_ff    <= index_in;
         pos_ff      <= pos_in;
         name_off_ff <= name_off_in;
         name_len_ff <= name_len_in;
         val_off_ff  <= val_off_in;
         val_len_ff  <= val_len_in;
         depth_ff    <= depth_in;
         esc_ff      <= esc_in;
         neg_ff      <= neg_in;
         mant_ff     <= mant_in;
         frac_ff     <= frac_in;
         point_ff    <= point_in;
         sat_ff      <= sat_in;
         err_ff      <= err_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RK_SUMMARY) |-> rsp_tlast)
      else $error("summary not marked last");

   a_entry_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == RK_ENTRY) |-> (rsp_tdata[114:112] == ERR_NONE))
      else $error("member entry carries an error code");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> (phase_ff == PH_IDLE) && (pos_ff == '0) && (index_ff == '0))
      else $error("parser did not restart after buffer end");
`endif

endmodule

>>> test/flat_json_member_scanner_top_tb.sv
// Self-checking testbench for the flat JSON member scanner: text requests in, member entries and summaries out.
module flat_json_member_scanner_top_tb;
   import fjms_pkg::*;

   // Generous bound on the whole run; the slowest legal run stays well below it.
   localparam int CYCLE_LIMIT   = 10_000_000;
   // Cycles to keep watching after the last expected result has arrived.
   localparam int SETTLE_CYCLES = 20;
   // Target count of random text bytes.
   localparam int RANDOM_BYTES  = 1100;
   // Print at most this many mismatch lines; keep counting past it.
   localparam int REPORT_LINES  = 40;
   localparam logic [63:0] MAG_MAX = (64'd1 << MAG_W) - 64'd1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en;
   logic [7:0]            csr_wr_data;

   flat_json_member_scanner_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------------
   // Scanner mirror: its own copy of the capacity register and parse state.
   // ---------------------------------------------------------------------------
   logic [7:0]  cap_copy;
   phase_type   scan_phase;
   logic [1:0]  val_kind;
   logic [7:0]  member_cnt;
   logic [12:0] byte_pos;
   logic [11:0] name_off;
   logic [11:0] name_cnt;
   logic [11:0] val_off;
   logic [11:0] val_cnt;
   logic [7:0]  depth;
   bit          esc_pending;
   bit          minus_seen;
   bit          point_seen;
   bit          saturated;
   logic [63:0] magnitude;
   logic [4:0]  frac_cnt;
   logic [2:0]  held_err;

   result_type  produced[$];     // results raised by the request being scanned
   result_type  records_due[$];  // entries and summaries the block still owes

   // Stimulus and bookkeeping.
   logic [7:0]  text_buf[$];
   bit          no_idle;
   int          mismatches;
   int          results_seen;
   int          cycle_count;

   function automatic bit is_blank(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   task automatic clear_scan();
      scan_phase  = PH_IDLE;
      val_kind    = VT_OBJECT;
      member_cnt  = '0;
      byte_pos    = '0;
      name_off    = '0;
      name_cnt    = '0;
      val_off     = '0;
      val_cnt     = '0;
      depth       = '0;
      esc_pending = 1'b0;
      minus_seen  = 1'b0;
      point_seen  = 1'b0;
      saturated   = 1'b0;
      magnitude   = '0;
      frac_cnt    = '0;
      held_err    = ERR_NONE;
   endtask

   task automatic fail_scan(input logic [2:0] code);
      held_err   = code;
      scan_phase = PH_DONE;
   endtask

   // Raise one member entry from the current name and value.
   task automatic emit_member();
      result_type r;
      r = '0;
      r.result_kind       = RK_ENTRY;
      r.data.entry_number = member_cnt;
      r.data.name_start   = name_off;
      r.data.name_len     = name_cnt;
      r.data.value_type   = val_kind;
      r.data.value_start  = val_off;
      r.data.value_len    = val_cnt;
      if (val_kind == VT_NUMBER) begin
         r.data.number_mantissa = minus_seen ? ~magnitude[MANT_BITS-1:0] + 1'b1
                                             : magnitude[MANT_BITS-1:0];
         r.data.fraction_digits = frac_cnt;
         r.data.number_overflow = saturated;
      end
      produced.push_back(r);
      member_cnt = member_cnt + 1'b1;
   endtask

   // A comma after a member: refuse it once the table is full.
   task automatic comma_seen();
      if (member_cnt >= cap_copy) begin
         fail_scan(ERR_ENTRIES);
      end else begin
         scan_phase = PH_AGAIN;
      end
   endtask

   task automatic number_char(input logic [7:0] c);
      logic [63:0] d;
      d = 64'(c) - 64'(CH_ZERO);
      if (c >= CH_ZERO && c <= CH_NINE) begin
         // Saturate the magnitude rather than wrap.
         if (magnitude > (MAG_MAX - d) / 10) begin
            magnitude = MAG_MAX;
            saturated = 1'b1;
         end else begin
            magnitude = magnitude * 10 + d;
         end
         if (point_seen) begin
            if (frac_cnt >= 5'd31) begin
               saturated = 1'b1;
            end else begin
               frac_cnt = frac_cnt + 1'b1;
            end
         end
         val_cnt = val_cnt + 1'b1;
      end else if (c == CH_POINT) begin
         if (point_seen) begin
            fail_scan(ERR_SYNTAX);
         end else begin
            point_seen = 1'b1;
            val_cnt    = val_cnt + 1'b1;
         end
      end else if (is_blank(c)) begin
         emit_member();
         scan_phase = PH_AFTERVALUE;
      end else if (c == CH_RBRACE) begin
         emit_member();
         scan_phase = PH_DONE;
      end else if (c == CH_COMMA) begin
         emit_member();
         comma_seen();
      end else begin
         fail_scan(ERR_SYNTAX);
      end
   endtask

   // Only brackets of the value's own kind move the depth.
   task automatic bracket_char(input logic [7:0] c, input logic [7:0] open_ch,
                               input logic [7:0] close_ch);
      if (c == close_ch) begin
         if (depth > 0) begin
            depth   = depth - 1'b1;
            val_cnt = val_cnt + 1'b1;
         end else begin
            emit_member();
            scan_phase = PH_AFTERVALUE;
         end
      end else begin
         if (c == open_ch && depth < NEST_LIMIT) depth = depth + 1'b1;
         val_cnt = val_cnt + 1'b1;
      end
   endtask

   task automatic start_value(input logic [7:0] c, input logic [12:0] pos);
      val_cnt     = '0;
      val_off     = pos[11:0] + 12'd1;
      depth       = '0;
      esc_pending = 1'b0;
      minus_seen  = 1'b0;
      magnitude   = '0;
      frac_cnt    = '0;
      point_seen  = 1'b0;
      saturated   = 1'b0;
      if (c == CH_QUOTE) begin
         val_kind   = VT_STRING;
         scan_phase = PH_VALUE;
      end else if (c == CH_LBRACE) begin
         val_kind   = VT_OBJECT;
         scan_phase = PH_VALUE;
      end else if (c == CH_LBRACK) begin
         val_kind   = VT_ARRAY;
         scan_phase = PH_VALUE;
      end else if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
         // A number's text starts at its first character, sign included.
         val_kind   = VT_NUMBER;
         val_off    = pos[11:0];
         val_cnt    = 12'd1;
         scan_phase = PH_VALUE;
         if (c == CH_MINUS) begin
            minus_seen = 1'b1;
         end else begin
            magnitude = 64'(c) - 64'(CH_ZERO);
         end
      end else begin
         fail_scan(ERR_SYNTAX);
      end
   endtask

   task automatic scan_char(input logic [7:0] c, input logic [12:0] pos);
      case (scan_phase)
         PH_IDLE, PH_AGAIN: begin
            // Skip blanks, and any brace while the first name is still awaited.
            if (!(is_blank(c) || (scan_phase == PH_IDLE && c == CH_LBRACE))) begin
               if (c == CH_QUOTE) begin
                  scan_phase = PH_NAME;
                  name_off   = pos[11:0] + 12'd1;
                  name_cnt   = '0;
               end else begin
                  fail_scan(ERR_NAME);
               end
            end
         end
         PH_NAME: begin
            if (c == CH_QUOTE) begin
               scan_phase = PH_AFTERNAME;
            end else begin
               name_cnt = name_cnt + 1'b1;
            end
         end
         PH_AFTERNAME: begin
            if (!is_blank(c)) begin
               if (c == CH_COLON) begin
                  scan_phase = PH_PREVALUE;
               end else begin
                  fail_scan(ERR_SYNTAX);
               end
            end
         end
         PH_PREVALUE: begin
            if (!is_blank(c)) start_value(c, pos);
         end
         PH_VALUE: begin
            if (val_kind == VT_STRING) begin
               if (esc_pending) begin
                  esc_pending = 1'b0;
                  val_cnt     = val_cnt + 1'b1;
               end else if (c == CH_QUOTE) begin
                  emit_member();
                  scan_phase = PH_AFTERVALUE;
               end else begin
                  if (c == CH_BSLASH) esc_pending = 1'b1;
                  val_cnt = val_cnt + 1'b1;
               end
            end else if (val_kind == VT_OBJECT) begin
               bracket_char(c, CH_LBRACE, CH_RBRACE);
            end else if (val_kind == VT_ARRAY) begin
               bracket_char(c, CH_LBRACK, CH_RBRACK);
            end else begin
               number_char(c);
            end
         end
         PH_AFTERVALUE: begin
            if (!is_blank(c)) begin
               if (c == CH_RBRACE) begin
                  scan_phase = PH_DONE;
               end else if (c == CH_COMMA) begin
                  comma_seen();
               end else begin
                  fail_scan(ERR_SYNTAX);
               end
            end
         end
         default: ;
      endcase
   endtask

   // Work out the results of one accepted request and queue them.
   task automatic scan_request(input logic [7:0] c, input bit last);
      logic [12:0] pos;
      result_type  r;
      pos = byte_pos;
      if (byte_pos < MAX_BUFFER) byte_pos = byte_pos + 1'b1;
      if (scan_phase != PH_DONE) begin
         // Offset first, then NUL, then zero capacity, then the grammar.
         if (pos >= MAX_BUFFER) begin
            fail_scan(ERR_TOO_LONG);
         end else if (c == CH_NUL) begin
            fail_scan(ERR_NUL);
         end else if (cap_copy == 0) begin
            fail_scan(ERR_ENTRIES);
         end else begin
            scan_char(c, pos);
         end
      end
      if (last) begin
         r = '0;
         r.result_kind       = RK_SUMMARY;
         r.data.entry_number = member_cnt;
         r.data.error_code   = held_err;
         r.last_of_run       = 1'b1;
         produced.push_back(r);
         clear_scan();
      end else if (produced.size() > 0) begin
         r = produced.pop_back();
         r.last_of_run = 1'b1;
         produced.push_back(r);
      end
      foreach (produced[i]) records_due.push_back(produced[i]);
      produced.delete();
   endtask

   // ---------------------------------------------------------------------------
   // Clock, timeout, result checking
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  records_due.size());
         $display("FAIL flat_json_member_scanner_top");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
         $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got,
                  want);
   endtask

   // Compare one accepted result, field by field, with the oldest one due.
   task automatic check_result();
      rsp_data_type got;
      result_type   want;
      got = rsp_tdata;
      if (records_due.size() == 0) begin
         report_mismatch("result with none due", rsp_tdata[63:0], '0);
         results_seen++;
         return;
      end
      want = records_due.pop_front();
      if (rsp_tuser !== want.result_kind)
         report_mismatch("result_kind", rsp_tuser, want.result_kind);
      if (rsp_tlast !== want.last_of_run)
         report_mismatch("last_of_run", rsp_tlast, want.last_of_run);
      if (got.entry_number !== want.data.entry_number)
         report_mismatch("entry_number", got.entry_number, want.data.entry_number);
      if (got.name_start !== want.data.name_start)
         report_mismatch("name_start", got.name_start, want.data.name_start);
      if (got.name_len !== want.data.name_len)
         report_mismatch("name_len", got.name_len, want.data.name_len);
      if (got.value_type !== want.data.value_type)
         report_mismatch("value_type", got.value_type, want.data.value_type);
      if (got.value_start !== want.data.value_start)
         report_mismatch("value_start", got.value_start, want.data.value_start);
      if (got.value_len !== want.data.value_len)
         report_mismatch("value_len", got.value_len, want.data.value_len);
      if (got.number_mantissa !== want.data.number_mantissa)
         report_mismatch("number_mantissa", got.number_mantissa, want.data.number_mantissa);
      if (got.fraction_digits !== want.data.fraction_digits)
         report_mismatch("fraction_digits", got.fraction_digits, want.data.fraction_digits);
      if (got.number_overflow !== want.data.number_overflow)
         report_mismatch("number_overflow", got.number_overflow, want.data.number_overflow);
      if (got.error_code !== want.data.error_code)
         report_mismatch("error_code", got.error_code, want.data.error_code);
      if (got.pad !== '0)
         report_mismatch("upper padding", got.pad, '0);
      results_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) check_result();
   end

   // ---------------------------------------------------------------------------
   // Idling on both sides
   // ---------------------------------------------------------------------------
   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else return $urandom_range(8, 40);
   endfunction

   // Result side: stall at random, except through stretches marked idle-free.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // Drive one request at a falling edge and hold it until a rising edge takes it.
   task automatic send_byte(input logic [7:0] c, input bit last);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      scan_request(c, last);
   endtask

   // Drop valid before any pause that is not a request gap.
   task automatic hold_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   task automatic drain_results();
      hold_requests();
      while (records_due.size() != 0) @(posedge clock);
   endtask

   // Write the capacity register with the block idle.
   task automatic set_capacity(input logic [7:0] cap);
      drain_results();
      // Allow for a request still in flight that raised no result.
      repeat (3) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cap_copy = cap;
   endtask

   // Send the buffered text as one buffer; stop and drain at pause_at if it is in range.
   task automatic send_frame(input int pause_at);
      for (int i = 0; i < text_buf.size(); i++) begin
         if (i == pause_at) drain_results();
         send_byte(text_buf[i], i == text_buf.size() - 1);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Text builders
   // ---------------------------------------------------------------------------
   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // A non-NUL byte, often a letter, never one of the two given.
   function automatic logic [7:0] text_byte(input logic [7:0] skip_a, input logic [7:0] skip_b);
      logic [7:0] c;
      do begin
         if ($urandom_range(0, 1)) c = $urandom_range(8'h61, 8'h7A);
         else c = $urandom_range(1, 255);
      end while (c == skip_a || c == skip_b);
      return c;
   endfunction

   task automatic add_blanks();
      logic [7:0] blank_set[4];
      blank_set = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
      if ($urandom_range(0, 1)) begin
         repeat ($urandom_range(1, 2)) text_buf.push_back(blank_set[$urandom_range(0, 3)]);
      end
   endtask

   task automatic add_string_body();
      repeat ($urandom_range(0, 8)) begin
         if ($urandom_range(0, 99) < 15) begin
            // Escape: the next byte, a quote included, stays inside the string.
            text_buf.push_back(CH_BSLASH);
            text_buf.push_back($urandom_range(1, 255));
         end else begin
            text_buf.push_back(text_byte(CH_QUOTE, CH_BSLASH));
         end
      end
   endtask

   task automatic add_bracketed(input logic [7:0] open_ch, input logic [7:0] close_ch,
                                input int level);
      text_buf.push_back(open_ch);
      repeat ($urandom_range(0, 5)) begin
         if (level < 2 && $urandom_range(0, 4) == 0) add_bracketed(open_ch, close_ch, level + 1);
         else text_buf.push_back(text_byte(open_ch, close_ch));
      end
      text_buf.push_back(close_ch);
   endtask

   task automatic add_number();
      int  r;
      int  int_digits;
      int  frac_digits;
      bit  neg;
      neg = ($urandom_range(0, 2) == 0);
      if (neg) text_buf.push_back(CH_MINUS);
      r = $urandom_range(0, 99);
      // Long digit runs push the mantissa into saturation.
      if (r < 75) int_digits = $urandom_range(1, 4);
      else if (r < 88) int_digits = $urandom_range(5, 14);
      else int_digits = $urandom_range(15, 22);
      if (neg && $urandom_range(0, 19) == 0) int_digits = 0;
      repeat (int_digits) text_buf.push_back($urandom_range(CH_ZERO, CH_NINE));
      r = $urandom_range(0, 99);
      if (r < 35) begin
         text_buf.push_back(CH_POINT);
         // A few runs past 31 fraction digits.
         frac_digits = (r < 28) ? $urandom_range(0, 4) : $urandom_range(29, 36);
         repeat (frac_digits) text_buf.push_back($urandom_range(CH_ZERO, CH_NINE));
         if ($urandom_range(0, 29) == 0) text_buf.push_back(CH_POINT);
      end
   endtask

   task automatic add_value();
      logic [1:0] kind;
      kind = $urandom_range(0, 3);
      case (kind)
         VT_STRING: begin
            text_buf.push_back(CH_QUOTE);
            add_string_body();
            text_buf.push_back(CH_QUOTE);
         end
         VT_OBJECT: add_bracketed(CH_LBRACE, CH_RBRACE, 0);
         VT_ARRAY:  add_bracketed(CH_LBRACK, CH_RBRACK, 0);
         default:   add_number();
      endcase
   endtask

   // Mostly well-formed objects with random content; some noise, damage and truncation.
   task automatic build_frame();
      int r;
      int keep;
      text_buf.delete();
      r = $urandom_range(0, 99);
      if (r < 5) begin
         repeat ($urandom_range(1, 8)) text_buf.push_back($urandom_range(0, 255));
         return;
      end
      add_blanks();
      if (r < 90) text_buf.push_back(CH_LBRACE);
      if (r >= 80 && r < 90) begin
         add_blanks();
         text_buf.push_back(CH_LBRACE);
      end
      for (int i = 0; i < $urandom_range(0, 5); i++) begin
         if (i > 0) text_buf.push_back(CH_COMMA);
         add_blanks();
         text_buf.push_back(CH_QUOTE);
         repeat ($urandom_range(0, 6)) text_buf.push_back(text_byte(CH_QUOTE, CH_QUOTE));
         text_buf.push_back(CH_QUOTE);
         add_blanks();
         text_buf.push_back(CH_COLON);
         add_blanks();
         add_value();
         add_blanks();
      end
      if ($urandom_range(0, 99) < 85) text_buf.push_back(CH_RBRACE);
      if ($urandom_range(0, 9) == 0) text_buf.push_back($urandom_range(0, 255));
      if (text_buf.size() == 0) text_buf.push_back(CH_SPACE);
      r = $urandom_range(0, 99);
      if (r < 15) begin
         text_buf[$urandom_range(0, text_buf.size() - 1)] = $urandom_range(0, 255);
      end else if (r < 25) begin
         // Cut short: the open member is dropped silently.
         keep = $urandom_range(1, text_buf.size());
         while (text_buf.size() > keep) void'(text_buf.pop_back());
      end
   endtask

   function automatic logic [7:0] choose_capacity();
      case ($urandom_range(0, 5))
         0:       return 8'd1;
         1:       return 8'd2;
         2:       return 8'd3;
         3:       return 8'd16;
         4:       return 8'd255;
         default: return $urandom_range(1, 255);
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------
   // Repeated brace, negative fraction, escaped quote, a byte after the close,
   // then a buffer of a single NUL.
   task automatic test_short_object();
      text_buf.delete();
      push_text(" {{\"a\":-9.5,\"b\":\"\\\"x\"}");
      text_buf.push_back(8'hFF);
      send_frame(-1);
      text_buf.delete();
      text_buf.push_back(CH_NUL);
      send_frame(-1);
   endtask

   // Capacity register: one entry, none, two, and the full 255.
   task automatic test_entry_capacity();
      set_capacity(8'd1);
      text_buf.delete();
      push_text("{\"a\":1,\"b\":2}");
      send_frame(-1);

      set_capacity(8'd0);
      text_buf.delete();
      push_text("{\"a\":1}");
      send_frame(-1);

      set_capacity(8'd2);
      text_buf.delete();
      push_text("{\"a\":\"\",\"b\":[]}");
      send_frame(-1);

      // Fill all 255 slots; the comma after the last one overflows the table.
      set_capacity(8'd255);
      text_buf.delete();
      text_buf.push_back(CH_LBRACE);
      for (int i = 0; i < 256; i++) begin
         text_buf.push_back(CH_QUOTE);
         text_buf.push_back(text_byte(CH_QUOTE, CH_QUOTE));
         text_buf.push_back(CH_QUOTE);
         text_buf.push_back(CH_COLON);
         text_buf.push_back($urandom_range(CH_ZERO, CH_NINE));
         text_buf.push_back(i == 255 ? CH_RBRACE : CH_COMMA);
      end
      send_frame(-1);
      set_capacity(8'd16);
   endtask

   // Array nested past the depth limit: extra opens are not counted.
   task automatic test_deep_nesting();
      text_buf.delete();
      push_text("{\"deep\":[");
      repeat (NEST_LIMIT + 45) text_buf.push_back(CH_LBRACK);
      repeat (NEST_LIMIT + 1) text_buf.push_back(CH_RBRACK);
      text_buf.push_back(CH_RBRACE);
      send_frame(-1);
   endtask

   // A near-full-size string value, then bytes past the end of the buffer space.
   task automatic test_oversized_buffer();
      text_buf.delete();
      push_text("{\"s\":\"");
      while (text_buf.size() < MAX_BUFFER - 2) text_buf.push_back(text_byte(CH_QUOTE, CH_BSLASH));
      text_buf.push_back(CH_QUOTE);
      text_buf.push_back(CH_COMMA);
      push_text("\"b\":1}");
      send_frame(-1);
   endtask

   task automatic test_random_buffers();
      int sent_total;
      int frames;
      int pause_at;
      sent_total = 0;
      frames     = 0;
      while (sent_total < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 12) set_capacity(choose_capacity());
         no_idle = ($urandom_range(0, 4) == 0);
         build_frame();
         // Stop mid-buffer until all results are in: always in the first buffer.
         pause_at = -1;
         if (frames == 0 || $urandom_range(0, 9) == 0)
            pause_at = $urandom_range(0, text_buf.size() - 1);
         send_frame(pause_at);
         sent_total += text_buf.size();
         frames++;
      end
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      no_idle      = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      cycle_count  = 0;
      cap_copy     = 8'd16;
      clear_scan();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_object();
      test_entry_capacity();
      test_deep_nesting();
      test_oversized_buffer();
      test_random_buffers();

      // Wait out the results still due, then watch a little longer for strays.
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (records_due.size() != 0) report_mismatch("results never delivered",
                                                   records_due.size(), '0);
      if (mismatches == 0) begin
         $display("PASS flat_json_member_scanner_top");
      end else begin
         $display("FAIL flat_json_member_scanner_top");
      end
      $finish;
   end

endmodule
